/* rtl/rhsv_pkg.sv */
package rhsv_pkg;

   // component width, used by the payload structs
   localparam int COMP_BITS = 16;
   localparam int THR_BITS  = 16;

   localparam longint unsigned TURN = 64'd1 << COMP_BITS;
   localparam logic [COMP_BITS-1:0] HUE_BASE_RED   = '0;
   localparam logic [COMP_BITS-1:0] HUE_BASE_GREEN = COMP_BITS'(TURN / 3);
   localparam logic [COMP_BITS-1:0] HUE_BASE_BLUE  = COMP_BITS'((2 * TURN) / 3);

   // divider shapes
   localparam int SAT_NUM_BITS = 2 * COMP_BITS;
   localparam int SAT_DEN_BITS = COMP_BITS;
   localparam int HUE_NUM_BITS = 2 * COMP_BITS;
   localparam int HUE_DEN_BITS = COMP_BITS + 3;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } rhsv_sector_type;

   typedef struct packed {
      logic [COMP_BITS-1:0] red;
      logic [COMP_BITS-1:0] green;
      logic [COMP_BITS-1:0] blue;
      logic [COMP_BITS-1:0] alpha_in;
   } rhsv_req_type;

   typedef struct packed {
      logic [COMP_BITS-1:0] hue;
      logic [COMP_BITS-1:0] saturation;
      logic [COMP_BITS-1:0] brightness;
      logic [COMP_BITS-1:0] alpha_out;
   } rhsv_rsp_type;

   // side data riding along the saturation divider
   typedef struct packed {
      logic                 dark;
      logic [COMP_BITS-1:0] brightness;
      logic [COMP_BITS-1:0] alpha;
   } rhsv_sat_side_type;

   // side data riding along the hue divider
   typedef struct packed {
      logic            grey;
      logic            neg;
      rhsv_sector_type sector;
   } rhsv_hue_side_type;

   function automatic logic [COMP_BITS-1:0] sector_base(rhsv_sector_type s);
      logic [COMP_BITS-1:0] b;
      case (s)
         SECTOR_RED:   b = HUE_BASE_RED;
         SECTOR_GREEN: b = HUE_BASE_GREEN;
         SECTOR_BLUE:  b = HUE_BASE_BLUE;
         default:      b = HUE_BASE_RED;
      endcase
      return b;
   endfunction

endpackage

/* rtl/rhsv_front.sv */
module rhsv_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  rhsv_pkg::rhsv_req_type              in_pixel,
   input  logic [rhsv_pkg::THR_BITS-1:0]       threshold,
   output logic                                out_valid,
   output logic [rhsv_pkg::SAT_NUM_BITS-1:0]   sat_num,
   output logic [rhsv_pkg::SAT_DEN_BITS-1:0]   sat_den,
   output rhsv_pkg::rhsv_sat_side_type         sat_side,
   output logic [rhsv_pkg::HUE_NUM_BITS-1:0]   hue_num,
   output logic [rhsv_pkg::HUE_DEN_BITS-1:0]   hue_den,
   output rhsv_pkg::rhsv_hue_side_type         hue_side
);
   import rhsv_pkg::*;

   localparam int N = COMP_BITS;

   logic            s1_valid_ff, s1_valid_in;
   logic [N-1:0]    s1_mx_ff, s1_mx_in;
   logic [N-1:0]    s1_mn_ff, s1_mn_in;
   logic [N-1:0]    s1_pos_ff, s1_pos_in;
   logic [N-1:0]    s1_neg_ff, s1_neg_in;
   logic [N-1:0]    s1_alpha_ff, s1_alpha_in;
   rhsv_sector_type s1_sector_ff, s1_sector_in;

   logic                    s2_valid_ff, s2_valid_in;
   logic [SAT_NUM_BITS-1:0] s2_sat_num_ff, s2_sat_num_in;
   logic [SAT_DEN_BITS-1:0] s2_sat_den_ff, s2_sat_den_in;
   rhsv_sat_side_type       s2_sat_side_ff, s2_sat_side_in;
   logic [HUE_NUM_BITS-1:0] s2_hue_num_ff, s2_hue_num_in;
   logic [HUE_DEN_BITS-1:0] s2_hue_den_ff, s2_hue_den_in;
   rhsv_hue_side_type       s2_hue_side_ff, s2_hue_side_in;

   logic [N-1:0] chroma;
   logic [N-1:0] diff;

   // stage one: max, min and sector pick
   always_comb begin
      logic [N-1:0] mx;
      logic [N-1:0] mn;
      mx = (in_pixel.red > in_pixel.green) ? in_pixel.red : in_pixel.green;
      if (in_pixel.blue > mx) mx = in_pixel.blue;
      mn = (in_pixel.red < in_pixel.green) ? in_pixel.red : in_pixel.green;
      if (in_pixel.blue < mn) mn = in_pixel.blue;
      s1_valid_in = in_valid;
      s1_mx_in    = mx;
      s1_mn_in    = mn;
      s1_alpha_in = in_pixel.alpha_in;
      if (mx == in_pixel.red) begin
         s1_sector_in = SECTOR_RED;
         s1_pos_in    = in_pixel.green;
         s1_neg_in    = in_pixel.blue;
      end else if (mx == in_pixel.green) begin
         s1_sector_in = SECTOR_GREEN;
         s1_pos_in    = in_pixel.blue;
         s1_neg_in    = in_pixel.red;
      end else begin
         s1_sector_in = SECTOR_BLUE;
         s1_pos_in    = in_pixel.red;
         s1_neg_in    = in_pixel.green;
      end
   end

   // stage two: chroma, offset sign, thresholds, divider operands
   assign chroma = s1_mx_ff - s1_mn_ff;
   assign diff   = (s1_pos_ff >= s1_neg_ff) ? (s1_pos_ff - s1_neg_ff)
                                            : (s1_neg_ff - s1_pos_ff);

   always_comb begin
      s2_valid_in               = s1_valid_ff;
      s2_sat_side_in.dark       = (33'(s1_mx_ff) < 33'(threshold)) || (s1_mx_ff == '0);
      s2_sat_side_in.brightness = s1_mx_ff;
      s2_sat_side_in.alpha      = s1_alpha_ff;
      s2_hue_side_in.grey       = (33'(chroma) < 33'(threshold)) || (chroma == '0);
      s2_hue_side_in.neg        = s1_pos_ff < s1_neg_ff;
      s2_hue_side_in.sector     = s1_sector_ff;
      // chroma * full scale as a shift and subtract
      s2_sat_num_in = {chroma, {N{1'b0}}} - SAT_NUM_BITS'(chroma);
      s2_sat_den_in = s1_mx_ff;
      s2_hue_num_in = {diff, {N{1'b0}}};
      // six times chroma
      s2_hue_den_in = (HUE_DEN_BITS'(chroma) << 2) + (HUE_DEN_BITS'(chroma) << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mx_ff       <= s1_mx_in;
      s1_mn_ff       <= s1_mn_in;
      s1_pos_ff      <= s1_pos_in;
      s1_neg_ff      <= s1_neg_in;
      s1_alpha_ff    <= s1_alpha_in;
      s1_sector_ff   <= s1_sector_in;
      s2_sat_num_ff  <= s2_sat_num_in;
      s2_sat_den_ff  <= s2_sat_den_in;
      s2_sat_side_ff <= s2_sat_side_in;
      s2_hue_num_ff  <= s2_hue_num_in;
      s2_hue_den_ff  <= s2_hue_den_in;
      s2_hue_side_ff <= s2_hue_side_in;
   end

   assign out_valid = s2_valid_ff;
   assign sat_num   = s2_sat_num_ff;
   assign sat_den   = s2_sat_den_ff;
   assign sat_side  = s2_sat_side_ff;
   assign hue_num   = s2_hue_num_ff;
   assign hue_den   = s2_hue_den_ff;
   assign hue_side  = s2_hue_side_ff;

endmodule

/* rtl/rhsv_div.sv */
module rhsv_div #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 16,
   parameter int QUO_W  = 16,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);
   // quotient must fit QUO_W bits: num < den * 2**QUO_W
   localparam int CMP_W = DEN_W + QUO_W;

   logic              valid_ff [QUO_W];
   logic [CMP_W-1:0]  rem_ff   [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [QUO_W-1:0]  quo_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];

   // one quotient bit per stage, most significant first
   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int K = QUO_W - 1 - s;
      logic              src_valid;
      logic [CMP_W-1:0]  src_rem;
      logic [DEN_W-1:0]  src_den;
      logic [QUO_W-1:0]  src_quo;
      logic [SIDE_W-1:0] src_side;
      logic [CMP_W-1:0]  trial;
      logic              fits;
      logic              valid_in;
      logic [CMP_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (s == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = CMP_W'(in_num);
         assign src_den   = in_den;
         assign src_quo   = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[s-1];
         assign src_rem   = rem_ff[s-1];
         assign src_den   = den_ff[s-1];
         assign src_quo   = quo_ff[s-1];
         assign src_side  = side_ff[s-1];
      end

      // trial subtract of the shifted divisor
      assign trial    = CMP_W'(src_den) << K;
      assign fits     = src_rem >= trial;
      assign valid_in = src_valid;
      assign rem_in   = fits ? (src_rem - trial) : src_rem;
      assign quo_in   = fits ? (src_quo | (QUO_W'(1) << K)) : src_quo;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         den_ff[s]  <= src_den;
         quo_ff[s]  <= quo_in;
         side_ff[s] <= src_side;
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

/* rtl/rgb_to_hsv_converter_top.sv */
// channel   ports                          direction  meaning
// request   start, busy, req_pixel         in         one rgba pixel per accepted start
// result    rsp_valid, rsp_pixel           out        one hsv+alpha pixel, one-cycle strobe
// config    csr_wr_en, csr_wr_data         in         near-zero threshold write
//
// a request is taken on every cycle with start high; busy is tied low
// the pipeline has two front stages, one divider stage per quotient bit and
// one output stage; throughput one pixel per clock
// the restoring divider pipelines for saturation and hue set the depth
// synchronous reset clears all valid bits and sets the threshold to 1
// the receiver cannot stall, so results leave on their strobe cycle
module rgb_to_hsv_converter_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  rhsv_pkg::rhsv_req_type        req_pixel,
   output logic                          rsp_valid,
   output rhsv_pkg::rhsv_rsp_type        rsp_pixel,
   input  logic                          csr_wr_en,
   input  logic [rhsv_pkg::THR_BITS-1:0] csr_wr_data
);
   import rhsv_pkg::*;

   localparam int N       = COMP_BITS;
   localparam int LATENCY = N + 3;

   logic [THR_BITS-1:0] thr_ff, thr_in;

   logic                    fr_valid;
   logic [SAT_NUM_BITS-1:0] fr_sat_num;
   logic [SAT_DEN_BITS-1:0] fr_sat_den;
   rhsv_sat_side_type       fr_sat_side;
   logic [HUE_NUM_BITS-1:0] fr_hue_num;
   logic [HUE_DEN_BITS-1:0] fr_hue_den;
   rhsv_hue_side_type       fr_hue_side;

   logic              sd_valid;
   logic [N-1:0]      sd_quo;
   rhsv_sat_side_type sd_side;
   logic              hd_valid;
   logic [N-1:0]      hd_quo;
   rhsv_hue_side_type hd_side;

   logic         rsp_valid_ff, rsp_valid_in;
   rhsv_rsp_type rsp_pixel_ff, rsp_pixel_in;

   // threshold register
   assign thr_in = csr_wr_en ? csr_wr_data : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_BITS'(1);
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign busy = 1'b0;

   rhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_pixel  (req_pixel),
      .threshold (thr_ff),
      .out_valid (fr_valid),
      .sat_num   (fr_sat_num),
      .sat_den   (fr_sat_den),
      .sat_side  (fr_sat_side),
      .hue_num   (fr_hue_num),
      .hue_den   (fr_hue_den),
      .hue_side  (fr_hue_side)
   );

   rhsv_div #(
      .NUM_W  (SAT_NUM_BITS),
      .DEN_W  (SAT_DEN_BITS),
      .QUO_W  (N),
      .SIDE_W ($bits(rhsv_sat_side_type))
   ) u_sat_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_num    (fr_sat_num),
      .in_den    (fr_sat_den),
      .in_side   (fr_sat_side),
      .out_valid (sd_valid),
      .out_quo   (sd_quo),
      .out_side  (sd_side)
   );

   rhsv_div #(
      .NUM_W  (HUE_NUM_BITS),
      .DEN_W  (HUE_DEN_BITS),
      .QUO_W  (N),
      .SIDE_W ($bits(rhsv_hue_side_type))
   ) u_hue_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_num    (fr_hue_num),
      .in_den    (fr_hue_den),
      .in_side   (fr_hue_side),
      .out_valid (hd_valid),
      .out_quo   (hd_quo),
      .out_side  (hd_side)
   );

   // hue assembly and zero rules
   always_comb begin
      logic [N-1:0] base;
      base         = sector_base(hd_side.sector);
      rsp_valid_in = sd_valid;
      rsp_pixel_in.brightness = sd_side.brightness;
      rsp_pixel_in.alpha_out  = sd_side.alpha;
      rsp_pixel_in.saturation = sd_side.dark ? '0 : sd_quo;
      if (sd_side.dark || hd_side.grey) begin
         rsp_pixel_in.hue = '0;
      end else if (hd_side.neg) begin
         rsp_pixel_in.hue = base - hd_quo;
      end else begin
         rsp_pixel_in.hue = base + hd_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

   // both divider pipelines stay in lockstep
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      sd_valid == hd_valid)
      else $error("divider valid bits out of step");

   // every request gives a result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_valid)
      else $error("result missing after request");

   // a black pixel has no hue and no saturation
   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pixel.brightness == '0) |->
         (rsp_pixel.hue == '0 && rsp_pixel.saturation == '0))
      else $error("black pixel with hue or saturation");

endmodule

/* test/rgb_to_hsv_converter_top_tb.sv */
module rgb_to_hsv_converter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rhsv_pkg::*;

   localparam int LATENCY   = COMP_BITS + 3;
   localparam int MAX_CYCLES = 400000;

   // hsv pixel predictor and in-order store of expected pixels
   class hsv_scoreboard;
      rhsv_rsp_type pending_pixels[$];
      logic [THR_BITS-1:0] threshold;
      int mismatches;
      int checked;

      function void set_threshold(logic [THR_BITS-1:0] t);
         threshold = t;
      endfunction

      function rhsv_rsp_type convert(rhsv_req_type p);
         rhsv_rsp_type o;
         longint unsigned r, g, b, mx, mn, chroma, hue, sat, base, pos, neg, mag, fs, turn;
         rhsv_sector_type sector;
         fs = (64'd1 << COMP_BITS) - 1;
         turn = 64'd1 << COMP_BITS;
         r = p.red;
         g = p.green;
         b = p.blue;
         mx = (r > g) ? r : g;
         if (b > mx) mx = b;
         mn = (r < g) ? r : g;
         if (b < mn) mn = b;
         chroma = mx - mn;
         hue = 0;
         sat = 0;
         if (mx >= threshold && mx != 0) begin
            sat = (chroma * fs) / mx;
            if (chroma >= threshold && chroma != 0) begin
               // sector priority red, green, blue on ties
               if (mx == r) sector = SECTOR_RED;
               else if (mx == g) sector = SECTOR_GREEN;
               else sector = SECTOR_BLUE;
               case (sector)
                  SECTOR_RED: begin
                     base = 0; pos = g; neg = b;
                  end
                  SECTOR_GREEN: begin
                     base = turn / 3; pos = b; neg = r;
                  end
                  default: begin
                     base = (2 * turn) / 3; pos = r; neg = g;
                  end
               endcase
               if (pos >= neg) begin
                  mag = ((pos - neg) * turn) / (6 * chroma);
                  hue = base + mag;
               end else begin
                  mag = ((neg - pos) * turn) / (6 * chroma);
                  hue = base + turn - mag;
               end
            end
         end
         o.hue = hue[COMP_BITS-1:0];
         o.saturation = sat[COMP_BITS-1:0];
         o.brightness = mx[COMP_BITS-1:0];
         o.alpha_out = p.alpha_in;
         return o;
      endfunction

      function void note_request(rhsv_req_type p);
         pending_pixels.push_back(convert(p));
      endfunction

      function void report(string what, rhsv_rsp_type e, rhsv_rsp_type a);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected h=%h s=%h v=%h a=%h got h=%h s=%h v=%h a=%h",
                     what, e.hue, e.saturation, e.brightness, e.alpha_out,
                     a.hue, a.saturation, a.brightness, a.alpha_out);
      endfunction

      function void check_pixel(rhsv_rsp_type a);
         rhsv_rsp_type e;
         if (pending_pixels.size() == 0) begin
            e = '0;
            report("unexpected pixel", e, a);
            return;
         end
         e = pending_pixels.pop_front();
         checked++;
         if (a.hue !== e.hue) report("hue", e, a);
         if (a.saturation !== e.saturation) report("saturation", e, a);
         if (a.brightness !== e.brightness) report("brightness", e, a);
         if (a.alpha_out !== e.alpha_out) report("alpha", e, a);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   rhsv_req_type req_pixel;
   logic rsp_valid;
   rhsv_rsp_type rsp_pixel;
   logic csr_wr_en;
   logic [THR_BITS-1:0] csr_wr_data;

   hsv_scoreboard sb;
   int cycle_count;
   int idle_pct;
   int thresholds_used;

   rgb_to_hsv_converter_top u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_pixel(rsp_pixel),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result monitor and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) sb.check_pixel(rsp_pixel);
      if (cycle_count > MAX_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("rgb_to_hsv_converter_top_tb: errors");
         $finish;
      end
   end

   // one request, holding start until accepted; gaps follow idle_pct
   task automatic send_pixel(rhsv_req_type p);
      while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_pixel <= p;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(p);
   endtask

   task automatic go_idle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_BITS-1:0] t);
      csr_wr_en <= 1'b1;
      csr_wr_data <= t;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_threshold(t);
      thresholds_used++;
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(5, 0))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'($urandom_range(15, 0));
         3: return 16'(16'hfff0 + $urandom_range(15, 0));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic rhsv_req_type rand_pixel();
      rhsv_req_type p;
      logic [15:0] v;
      p.red = rand_comp();
      p.green = rand_comp();
      p.blue = rand_comp();
      p.alpha_in = 16'($urandom);
      // ties between components
      v = p.red;
      case ($urandom_range(7, 0))
         0: p.green = v;
         1: p.blue = v;
         2: begin
            p.green = v; p.blue = v;
         end
         3: p.blue = p.green;
         default: ;
      endcase
      return p;
   endfunction

   function automatic rhsv_req_type mk(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                       logic [15:0] a);
      rhsv_req_type p;
      p.red = r; p.green = g; p.blue = b; p.alpha_in = a;
      return p;
   endfunction

   initial begin
      logic [THR_BITS-1:0] thr_list[6];
      int phase_idle[4];
      sb = new();
      sb.set_threshold(16'd1);
      cycle_count = 0;
      thresholds_used = 0;
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_pixel = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, dark, grey, ties, negative red offset, each sector
      send_pixel(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_pixel(mk(16'hffff, 16'hffff, 16'hffff, 16'hffff));
      send_pixel(mk(16'hffff, 16'h0000, 16'h0000, 16'h1234));
      send_pixel(mk(16'h0000, 16'hffff, 16'h0000, 16'h5555));
      send_pixel(mk(16'h0000, 16'h0000, 16'hffff, 16'haaaa));
      send_pixel(mk(16'hffff, 16'h0000, 16'h0001, 16'h0001));
      send_pixel(mk(16'hffff, 16'hffff, 16'h0000, 16'h8000));
      send_pixel(mk(16'h0000, 16'hffff, 16'hffff, 16'h7fff));
      send_pixel(mk(16'hffff, 16'h0000, 16'hffff, 16'h00ff));
      send_pixel(mk(16'h0001, 16'h0000, 16'h0000, 16'hff00));
      send_pixel(mk(16'h8000, 16'h7fff, 16'h8000, 16'h0f0f));
      send_pixel(mk(16'h1000, 16'h0fff, 16'h0ffe, 16'hf0f0));
      send_pixel(mk(16'h0003, 16'h0001, 16'h0002, 16'h3333));
      go_idle();
      write_threshold(16'd0);
      send_pixel(mk(16'h0000, 16'h0000, 16'h0000, 16'hcccc));
      send_pixel(mk(16'h0005, 16'h0005, 16'h0005, 16'h0001));
      send_pixel(mk(16'h0002, 16'h0000, 16'h0001, 16'h0002));
      go_idle();
      write_threshold(16'hffff);
      send_pixel(mk(16'hfffe, 16'h0000, 16'h0000, 16'h0003));
      send_pixel(mk(16'hffff, 16'h0000, 16'h0000, 16'h0004));
      send_pixel(mk(16'hffff, 16'h0001, 16'h0000, 16'h0005));
      go_idle();
      write_threshold(16'h0100);
      send_pixel(mk(16'h0100, 16'h0080, 16'h0090, 16'h0006));
      send_pixel(mk(16'h00ff, 16'h0000, 16'h0000, 16'h0007));
      send_pixel(mk(16'h4000, 16'h3f01, 16'h3f00, 16'h0008));
      go_idle();

      // random phases across idling levels and thresholds
      thr_list = '{16'd1, 16'd0, 16'hffff, 16'd16, 16'h8000, 16'd1};
      phase_idle = '{0, 81, 0, 14};
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 5) write_threshold(16'($urandom_range(64, 2)));
         else write_threshold(thr_list[ph]);
         for (int i = 0; i < 290; i++) begin
            idle_pct = (i % 97 < 20) ? 0 : phase_idle[ph % 4];
            send_pixel(rand_pixel());
         end
         idle_pct = 0;
         go_idle();
      end

      $display("covered %0d pixels over %0d threshold settings, idle gaps up to 81 percent",
               sb.checked, thresholds_used);
      if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
         $display("rgb_to_hsv_converter_top_tb: clean");
      end else begin
         $display("%0d mismatches, %0d pixels missing", sb.mismatches,
                  sb.pending_pixels.size());
         $display("rgb_to_hsv_converter_top_tb: errors");
      end
      $finish;
   end
endmodule
